/* sv/ledsd_pkg.sv */
package ledsd_pkg;

  localparam int VALUE_W        = 31;
  localparam int COLOR_W        = 32;
  localparam int IDX_W          = 16;
  localparam int LEN_W          = 16;
  localparam int LPS_W          = 8;
  localparam int SPACE_W        = 8;
  localparam int WIDTH_W        = 11;  // 7 * 255 + 255 fits in 11 bits
  localparam int SEG_W          = 7;
  localparam int MAX_DIGITS_DEF = 8;

  localparam int IN_TDATA_W  = 64;
  localparam int OUT_TDATA_W = 48;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_SEG_START  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SEG_LENGTH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LEDS_PER   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPACING    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BLANK_EN   = 3'd4;

  // Position of segment G, the last one of a digit in wire order.
  localparam logic [2:0] SEG_LAST = 3'd6;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_EMIT
  } ledsd_state_t;

  // Bit s is segment s in wire order F, A, B, C, D, E, G.
  function automatic logic [SEG_W-1:0] seg_pattern(input logic [3:0] digit);
    logic [SEG_W-1:0] pat;
    case (digit)
      4'd0:    pat = 7'h3F;
      4'd1:    pat = 7'h0C;
      4'd2:    pat = 7'h76;
      4'd3:    pat = 7'h5E;
      4'd4:    pat = 7'h4D;
      4'd5:    pat = 7'h5B;
      4'd6:    pat = 7'h7B;
      4'd7:    pat = 7'h0E;
      4'd8:    pat = 7'h7F;
      4'd9:    pat = 7'h6F;
      default: pat = '0;
    endcase
    return pat;
  endfunction

endpackage

/* sv/ledsd_bcd_conv.sv */
module ledsd_bcd_conv #(
  parameter int MAX_DIGITS = ledsd_pkg::MAX_DIGITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [ledsd_pkg::VALUE_W-1:0] value,
  output logic                          busy,
  output logic [4*MAX_DIGITS-1:0]       bcd
);
  import ledsd_pkg::*;

  localparam int CNT_W = $clog2(VALUE_W + 1);
  localparam int BCD_W = 4 * MAX_DIGITS;

  logic [VALUE_W-1:0] shift_r, shift_nxt;
  logic [BCD_W-1:0]   bcd_r, bcd_nxt, adj;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;

  // One bit per cycle; digits carried out of the top are dropped, which
  // leaves the value modulo 10 to the power of MAX_DIGITS.
  always_comb begin
    for (int d = 0; d < MAX_DIGITS; d++) begin
      adj[4*d +: 4] = (bcd_r[4*d +: 4] >= 4'd5) ? bcd_r[4*d +: 4] + 4'd3 : bcd_r[4*d +: 4];
    end
    shift_nxt = shift_r;
    bcd_nxt   = bcd_r;
    cnt_nxt   = cnt_r;
    if (start) begin
      shift_nxt = value;
      bcd_nxt   = '0;
      cnt_nxt   = CNT_W'(VALUE_W);
    end else if (cnt_r != '0) begin
      shift_nxt = {shift_r[VALUE_W-2:0], 1'b0};
      if (BCD_W > 1) begin
        bcd_nxt = {adj[BCD_W-2:0], shift_r[VALUE_W-1]};
      end
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    shift_r <= shift_nxt;
    bcd_r   <= bcd_nxt;
  end

  assign busy = (cnt_r != '0);
  assign bcd  = bcd_r;

endmodule

/* sv/ledsd_digit_cnt.sv */
module ledsd_digit_cnt #(
  parameter int MAX_DIGITS = ledsd_pkg::MAX_DIGITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [ledsd_pkg::LEN_W-1:0]   seg_length,
  input  logic [ledsd_pkg::WIDTH_W-1:0] digit_width,
  output logic [$clog2(MAX_DIGITS+1)-1:0] count
);
  import ledsd_pkg::*;

  localparam int CW = $clog2(MAX_DIGITS + 1);

  logic [LEN_W-1:0] rem_r, rem_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic [LEN_W-1:0] wide_width;

  assign wide_width = {{(LEN_W-WIDTH_W){1'b0}}, digit_width};

  // Repeated subtraction, stopped at the digit cap, so at most MAX_DIGITS steps.
  always_comb begin
    rem_nxt = rem_r;
    cnt_nxt = cnt_r;
    if (start) begin
      rem_nxt = seg_length;
      cnt_nxt = '0;
    end else if ((digit_width != '0) && (rem_r >= wide_width) &&
                 (cnt_r < CW'(MAX_DIGITS))) begin
      rem_nxt = rem_r - wide_width;
      cnt_nxt = cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    rem_r <= rem_nxt;
  end

  assign count = cnt_r;

endmodule

/* sv/ledsd_seg_emit.sv */
module ledsd_seg_emit #(
  parameter int MAX_DIGITS = ledsd_pkg::MAX_DIGITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [4*MAX_DIGITS-1:0]         bcd,
  input  logic [$clog2(MAX_DIGITS+1)-1:0] count,
  input  logic [ledsd_pkg::COLOR_W-1:0]   color,
  input  logic [ledsd_pkg::IDX_W-1:0]     seg_start,
  input  logic [ledsd_pkg::LPS_W-1:0]     leds_per_seg,
  input  logic [ledsd_pkg::WIDTH_W-1:0]   digit_width,
  input  logic                            blank_en,
  input  logic                            out_ready,
  output logic                            out_valid,
  output logic [ledsd_pkg::IDX_W-1:0]     led_index,
  output logic [ledsd_pkg::COLOR_W-1:0]   pixel_color,
  output logic                            last,
  output logic                            active
);
  import ledsd_pkg::*;

  localparam int CW    = $clog2(MAX_DIGITS + 1);
  localparam int BCD_W = 4 * MAX_DIGITS;

  logic [BCD_W-1:0]      dig_r, dig_nxt;
  logic [MAX_DIGITS-1:0] keep_r, keep_nxt, keep_init;
  logic [CW-1:0]         dleft_r, dleft_nxt;
  logic [2:0]            seg_r, seg_nxt;
  logic [IDX_W-1:0]      base_r, base_nxt, idx_r, idx_nxt, wide_width;
  logic                  act_r, act_nxt;
  logic                  ov_r, ov_nxt;
  logic [IDX_W-1:0]      oidx_r, oidx_nxt;
  logic [COLOR_W-1:0]    ocol_r, ocol_nxt;
  logic                  olast_r, olast_nxt;
  logic [SEG_W-1:0]      pattern;
  logic                  step;

  assign wide_width = {{(IDX_W-WIDTH_W){1'b0}}, digit_width};

  // A digit stays visible if it or any digit above it within the count is nonzero.
  always_comb begin
    logic acc;
    acc = 1'b0;
    for (int j = MAX_DIGITS - 1; j >= 0; j--) begin
      if ((CW'(j) < count) && (bcd[4*j +: 4] != 4'd0)) begin
        acc = 1'b1;
      end
      keep_init[j] = acc;
    end
  end

  assign pattern = (keep_r[0] || !blank_en) ? seg_pattern(dig_r[3:0]) : '0;
  assign step    = act_r && (!ov_r || out_ready);

  always_comb begin
    dig_nxt   = dig_r;
    keep_nxt  = keep_r;
    dleft_nxt = dleft_r;
    seg_nxt   = seg_r;
    base_nxt  = base_r;
    idx_nxt   = idx_r;
    act_nxt   = act_r;
    ov_nxt    = ov_r && !out_ready;
    oidx_nxt  = oidx_r;
    ocol_nxt  = ocol_r;
    olast_nxt = olast_r;
    if (start) begin
      dig_nxt   = bcd;
      keep_nxt  = keep_init;
      dleft_nxt = count;
      seg_nxt   = '0;
      base_nxt  = seg_start;
      idx_nxt   = seg_start;
      act_nxt   = (count != '0);
    end else if (step) begin
      ov_nxt    = 1'b1;
      oidx_nxt  = idx_r;
      ocol_nxt  = pattern[seg_r] ? color : '0;
      olast_nxt = (dleft_r == CW'(1)) && (seg_r == SEG_LAST);
      if (seg_r == SEG_LAST) begin
        seg_nxt   = '0;
        base_nxt  = base_r + wide_width;
        idx_nxt   = base_r + wide_width;
        dig_nxt   = dig_r >> 4;
        keep_nxt  = keep_r >> 1;
        dleft_nxt = dleft_r - 1'b1;
        if (dleft_r == CW'(1)) begin
          act_nxt = 1'b0;
        end
      end else begin
        seg_nxt = seg_r + 1'b1;
        idx_nxt = idx_r + {{(IDX_W-LPS_W){1'b0}}, leds_per_seg};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= 1'b0;
      ov_r  <= 1'b0;
    end else begin
      act_r <= act_nxt;
      ov_r  <= ov_nxt;
    end
    dig_r   <= dig_nxt;
    keep_r  <= keep_nxt;
    dleft_r <= dleft_nxt;
    seg_r   <= seg_nxt;
    base_r  <= base_nxt;
    idx_r   <= idx_nxt;
    oidx_r  <= oidx_nxt;
    ocol_r  <= ocol_nxt;
    olast_r <= olast_nxt;
  end

  assign out_valid   = ov_r;
  assign led_index   = oidx_r;
  assign pixel_color = ocol_r;
  assign last        = olast_r;
  assign active      = act_r;

endmodule

/* sv/led_strip_seven_segment_digits.sv */
// Renders a number on a row of seven-segment digits laid out along an LED strip.
// Each input transaction carries a value and a color; the block answers with one
// output transaction per segment, starting at the rightmost digit and running
// through each digit's segments in wire order F, A, B, C, D, E, G. A result gives
// the first strip LED of the segment and the color, or zero when the segment is
// dark or blanked, and tlast marks the final segment of the number. The digit
// count is segment_length / (7 * leds_per_segment + digit_spacing), capped at
// MAX_DIGITS; a count of zero produces no output at all. An item goes through
// bit-serial binary-to-decimal conversion and then segment output, one segment
// per cycle while out_tready stays high; a low out_tready holds a segment back.
// A new item is accepted only once the sequencer is back in idle, which follows
// the registering of the last segment (or, with a count of zero, the end of
// conversion), so the next conversion can overlap the delivery of that segment.
// Configuration is taken at any time but must only be changed while the block
// is idle.
module led_strip_seven_segment_digits #(
  parameter int MAX_DIGITS = ledsd_pkg::MAX_DIGITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // Input stream.
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [ledsd_pkg::IN_TDATA_W-1:0]  in_tdata,   // value[30:0], color[62:31]
  // Result stream.
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [ledsd_pkg::OUT_TDATA_W-1:0] out_tdata,  // led_index[15:0], pixel_color[47:16]
  output logic                              out_tlast,
  // Configuration writes.
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [ledsd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ledsd_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import ledsd_pkg::*;

  localparam int CW = $clog2(MAX_DIGITS + 1);

  // Configuration registers.
  logic [IDX_W-1:0]   seg_start_r;
  logic [LEN_W-1:0]   seg_length_r;
  logic [LPS_W-1:0]   leds_per_r;
  logic [SPACE_W-1:0] spacing_r;
  logic               blank_en_r;

  ledsd_state_t state_r, state_nxt;
  logic [COLOR_W-1:0] color_r;

  logic                  in_fire;
  logic                  conv_busy;
  logic [4*MAX_DIGITS-1:0] bcd;
  logic [CW-1:0]         digit_count;
  logic [WIDTH_W-1:0]    digit_width;
  logic                  emit_start;
  logic                  emit_active;
  logic [IDX_W-1:0]      out_idx;
  logic [COLOR_W-1:0]    out_color;

  // Width of one digit on the strip: seven segments plus the gap to the next digit.
  assign digit_width = ({leds_per_r, 3'b000} - {3'b000, leds_per_r}) +
                       {3'b000, spacing_r};

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_start_r  <= '0;
      seg_length_r <= '0;
      leds_per_r   <= LPS_W'(2);
      spacing_r    <= '0;
      blank_en_r   <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_SEG_START:  seg_start_r  <= cfg_data[IDX_W-1:0];
        CFG_SEG_LENGTH: seg_length_r <= cfg_data[LEN_W-1:0];
        CFG_LEDS_PER:   leds_per_r   <= cfg_data[LPS_W-1:0];
        CFG_SPACING:    spacing_r    <= cfg_data[SPACE_W-1:0];
        CFG_BLANK_EN:   blank_en_r   <= cfg_data[0];
        default:        ;
      endcase
    end
  end

  assign in_fire = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (in_fire) begin
      color_r <= in_tdata[VALUE_W +: COLOR_W];
    end
  end

  // Sequencer: accept, convert, hand the digits to the emitter; a zero count goes to idle.
  always_comb begin
    state_nxt  = state_r;
    in_tready  = 1'b0;
    emit_start = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          state_nxt = ST_CONV;
        end
      end
      ST_CONV: begin
        if (!conv_busy) begin
          if (digit_count == '0) begin
            state_nxt = ST_IDLE;
          end else begin
            emit_start = 1'b1;
            state_nxt  = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        if (!emit_active) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  ledsd_bcd_conv #(.MAX_DIGITS(MAX_DIGITS)) u_conv (
    .clk   (clk),
    .rst_n (rst_n),
    .start (in_fire),
    .value (in_tdata[VALUE_W-1:0]),
    .busy  (conv_busy),
    .bcd   (bcd)
  );

  ledsd_digit_cnt #(.MAX_DIGITS(MAX_DIGITS)) u_cnt (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (in_fire),
    .seg_length  (seg_length_r),
    .digit_width (digit_width),
    .count       (digit_count)
  );

  ledsd_seg_emit #(.MAX_DIGITS(MAX_DIGITS)) u_emit (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (emit_start),
    .bcd          (bcd),
    .count        (digit_count),
    .color        (color_r),
    .seg_start    (seg_start_r),
    .leds_per_seg (leds_per_r),
    .digit_width  (digit_width),
    .blank_en     (blank_en_r),
    .out_ready    (out_tready),
    .out_valid    (out_tvalid),
    .led_index    (out_idx),
    .pixel_color  (out_color),
    .last         (out_tlast),
    .active       (emit_active)
  );

  assign out_tdata = {out_color, out_idx};

  // The emitter must have finished before a new item can come in.
  a_idle_no_emit: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !emit_active)
    else $error("input accepted while segments are still being emitted");

  // An accepted item always starts a conversion.
  a_accept_conv: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r == ST_CONV) && conv_busy)
    else $error("accepted item did not start a conversion");

  // The digit count never passes the cap.
  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    digit_count <= CW'(MAX_DIGITS))
    else $error("digit count above cap");

  // The emitter is only started with a nonzero digit count, so it must go active on start.
  a_emit_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    emit_start |=> emit_active)
    else $error("emitter start did not take");

endmodule
